// ----- src/lookahead_envelope_level_control_assert.svh -----
// assertion macros for the look-ahead envelope level control
`ifndef LOOKAHEAD_ENVELOPE_LEVEL_CONTROL_ASSERT_SVH
`define LOOKAHEAD_ENVELOPE_LEVEL_CONTROL_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LELC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LELC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lelc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lelc_pkg
// shared types and constants for the look-ahead envelope level control
// ----------------------------------------------------------------------------
package lelc_pkg;
    localparam int Depth      = 64;
    localparam int PosW       = $clog2(Depth);
    localparam int QuietLimit = 5;
    localparam int QuietW     = $clog2(QuietLimit + 2);
    localparam int TargetLevel = 32000;
    localparam int RampFull   = 32767;

    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_MODE      = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [1:0] SLOPE_UNKNOWN = 2'd0;
    localparam logic [1:0] SLOPE_RISING  = 2'd1;
    localparam logic [1:0] SLOPE_FALLING = 2'd2;
    localparam logic [1:0] SLOPE_FLAT    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_DIV_OUT,
        ST_DECIDE,
        ST_R_START,
        ST_R_RD,
        ST_R_DIV,
        ST_R_WR,
        ST_R_END,
        ST_CHECK,
        ST_FINISH,
        ST_SEND
    } t_state;

    // divider request / status
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;
endpackage

// ----- src/lookahead_envelope_level_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookahead_envelope_level_control
// look-ahead envelope level control for 16-bit audio samples
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries i_sample_in; output channel
// o_valid/i_ready carries o_sample_out, one result per input transaction.
// The result is the sample that entered 64 transactions earlier, scaled by
// 32000/envelope. Each transaction runs through a sequencer that shares one
// 32-step bit-serial divider. o_valid rises after the output division when
// the envelope entry is nonzero, and without a division when it is zero. An
// envelope ramp over n entries adds one division per entry (n is at most 63).
// While bypassed (enable 0) the input goes straight to the output register.
// o_ready is high only in the idle state with no result pending, so one
// transaction is in work at a time and the next input is taken only after the
// result is accepted; a stalled receiver holds the result in the output
// register and the block waits. Reset is synchronous: the rings read as zero
// through per-entry valid bits, the write and corner pointers and the quiet
// counter clear, registers take enable 1, mode 1, threshold 10.
// ----------------------------------------------------------------------------
`include "lookahead_envelope_level_control_assert.svh"

module lookahead_envelope_level_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sample_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample_out
);
    localparam int PW = lelc_pkg::PosW;
    localparam int QW = lelc_pkg::QuietW;

    // configuration
    logic        r_enable, r_mode;
    logic [14:0] r_thr;

    // memories
    logic signed [15:0] r_smem [lelc_pkg::Depth];
    logic [15:0]        r_emem [lelc_pkg::Depth];
    logic [lelc_pkg::Depth-1:0] r_sval, r_evalid;
    logic signed [15:0] r_srd;
    logic [15:0]        r_erd;

    lelc_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_wp, r_lc, r_pos, r_tgt, r_peakp;
    logic signed [15:0] r_in, r_prev;
    logic [1:0]    r_pslope;
    logic [QW-1:0] r_quiet;
    logic [16:0]   r_level, r_start;
    logic [PW:0]   r_count, r_step;
    logic          r_zero_lc;   // zero the entry before the write position
    logic          r_did_check;
    logic signed [15:0] r_out;
    logic          r_ovalid;

    lelc_pkg::t_div_req w_req;
    lelc_pkg::t_div_rsp w_rsp;

    lelc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // memory read address and write controls
    logic [PW-1:0] w_raddr;
    logic          w_ewe, w_swe;
    logic [PW-1:0] w_eaddr;
    logic [15:0]   w_edata;

    // slope and peak detection
    logic [1:0]  w_slope;
    logic        w_found;
    logic [16:0] w_peak;
    logic [16:0] w_absin, w_absprev;
    logic [PW-1:0] w_peakp, w_next;
    always_comb begin
        w_slope = lelc_pkg::SLOPE_FLAT;
        if (r_prev > r_in) w_slope = lelc_pkg::SLOPE_FALLING;
        else if (r_prev < r_in) w_slope = lelc_pkg::SLOPE_RISING;
        w_absin   = r_in[15] ? 17'd0 - {r_in[15], r_in} : {1'b0, r_in};
        w_absprev = r_prev[15] ? 17'd0 - {r_prev[15], r_prev} : {1'b0, r_prev};
        w_found = 1'b0;
        w_peak  = w_absprev;
        if (!r_prev[15] && r_prev != 16'sd0 && r_pslope == lelc_pkg::SLOPE_RISING &&
            w_slope == lelc_pkg::SLOPE_FALLING && w_absprev > {2'b0, r_thr})
            w_found = 1'b1;
        if (r_prev[15] && r_pslope == lelc_pkg::SLOPE_FALLING &&
            w_slope == lelc_pkg::SLOPE_RISING && w_absprev > {2'b0, r_thr})
            w_found = 1'b1;
        w_peakp = r_wp - PW'(1);
        w_next  = r_wp + PW'(1);
    end

    // silence gating and window checks
    logic w_quiet_hit, w_quiet_ramp, w_quiet_zero, w_wrap_ramp;
    always_comb begin
        w_quiet_hit  = !w_found && r_mode && (w_absin < {2'b0, r_thr});
        w_quiet_ramp = w_quiet_hit && (r_quiet + QW'(1) == QW'(lelc_pkg::QuietLimit));
        w_quiet_zero = w_quiet_hit && (r_quiet >= QW'(lelc_pkg::QuietLimit));
        w_wrap_ramp  = !r_did_check && (r_lc == w_next);
    end

    // ramp value: start + quotient, raised to stored magnitude above the threshold
    logic [16:0] w_mag;
    logic signed [33:0] w_env;
    logic [15:0] w_envw;
    always_comb begin
        w_mag = r_srd[15] ? 17'd0 - {r_srd[15], r_srd} : {1'b0, r_srd};
        w_env = $signed({17'd0, r_start}) + $signed({{2{w_rsp.quo[31]}}, w_rsp.quo});
        w_envw = w_env[15:0];
        if (w_mag > {2'b0, r_thr} && $signed({17'd0, w_mag}) > w_env) w_envw = w_mag[15:0];
    end

    logic signed [17:0] w_diff;
    logic signed [25:0] w_prod;
    always_comb begin
        w_diff = $signed({1'b0, r_level}) - $signed({1'b0, r_start});
        w_prod = w_diff * $signed({1'b0, r_step});
    end

    logic [31:0] w_sprod;
    always_comb w_sprod = 32'($signed(r_srd) * 32'sd32000);

    // sequencer
    always_comb begin
        n_state = r_state;
        w_req   = '0;
        w_raddr = r_pos;
        w_ewe = 1'b0; w_swe = 1'b0;
        w_eaddr = r_pos; w_edata = w_envw;
        unique case (r_state)
            lelc_pkg::ST_IDLE: begin
                w_raddr = r_wp;
                if (i_valid && o_ready)
                    n_state = r_enable ? lelc_pkg::ST_RD_OUT : lelc_pkg::ST_SEND;
            end
            lelc_pkg::ST_RD_OUT: begin
                w_raddr = r_wp;
                if (r_erd != 16'd0) begin
                    w_req.start = 1'b1;
                    w_req.neg   = w_sprod[31];
                    w_req.num   = w_sprod[31] ? 32'd0 - w_sprod : w_sprod;
                    w_req.den   = r_erd;
                    n_state = lelc_pkg::ST_DIV_OUT;
                end else n_state = lelc_pkg::ST_DECIDE;
            end
            lelc_pkg::ST_DIV_OUT: if (w_rsp.done) n_state = lelc_pkg::ST_DECIDE;
            lelc_pkg::ST_DECIDE:
                n_state = (w_found || w_quiet_ramp) ? lelc_pkg::ST_R_START
                                                    : lelc_pkg::ST_CHECK;
            lelc_pkg::ST_R_START: begin
                w_raddr = r_pos;
                n_state = lelc_pkg::ST_R_RD;
            end
            lelc_pkg::ST_R_RD: begin
                if (r_pos == r_tgt) n_state = lelc_pkg::ST_R_END;
                else begin
                    w_req.start = 1'b1;
                    w_req.neg   = w_prod[25];
                    w_req.num   = 32'(w_prod[25] ? -w_prod : w_prod);
                    w_req.den   = 16'(r_count);
                    n_state = lelc_pkg::ST_R_DIV;
                end
            end
            lelc_pkg::ST_R_DIV: if (w_rsp.done) n_state = lelc_pkg::ST_R_WR;
            lelc_pkg::ST_R_WR: begin
                w_ewe = 1'b1;
                n_state = lelc_pkg::ST_R_START;
            end
            lelc_pkg::ST_R_END: begin
                w_ewe = 1'b1; w_edata = r_level[15:0];
                n_state = lelc_pkg::ST_CHECK;
            end
            lelc_pkg::ST_CHECK:
                n_state = w_wrap_ramp ? lelc_pkg::ST_R_START : lelc_pkg::ST_FINISH;
            lelc_pkg::ST_FINISH: begin
                w_swe = 1'b1;
                n_state = lelc_pkg::ST_SEND;
            end
            lelc_pkg::ST_SEND: if (!r_ovalid) n_state = lelc_pkg::ST_IDLE;
            default: n_state = lelc_pkg::ST_IDLE;
        endcase
    end

    // memory access
    always_ff @(posedge i_clk) begin
        r_srd <= r_sval[w_raddr] ? r_smem[w_raddr] : 16'sd0;
        r_erd <= r_evalid[w_raddr] ? r_emem[w_raddr] : 16'd0;
        if (w_ewe) r_emem[w_eaddr] <= w_edata;
        if (w_swe) r_smem[r_wp] <= r_in;
        if (r_state == lelc_pkg::ST_CHECK && r_zero_lc) r_emem[r_peakp] <= 16'd0;
    end

    // sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lelc_pkg::ST_IDLE;
            r_enable <= 1'b1;
            r_mode   <= 1'b1;
            r_thr    <= 15'd10;
            r_sval   <= '0;
            r_evalid <= '0;
            r_wp <= '0; r_lc <= '0;
            r_prev <= '0; r_pslope <= lelc_pkg::SLOPE_UNKNOWN;
            r_quiet <= '0;
            r_ovalid <= 1'b0;
            r_zero_lc <= 1'b0;
            r_did_check <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lelc_pkg::REG_ENABLE:    r_enable <= i_cfg_data[0];
                    lelc_pkg::REG_MODE:      r_mode   <= i_cfg_data[0];
                    lelc_pkg::REG_THRESHOLD: r_thr    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (w_ewe) r_evalid[w_eaddr] <= 1'b1;
            if (w_swe) r_sval[r_wp] <= 1'b1;
            unique case (r_state)
                lelc_pkg::ST_IDLE: if (i_valid && o_ready) begin
                    r_in <= i_sample_in;
                    r_out <= r_enable ? 16'sd0 : i_sample_in;
                    r_did_check <= 1'b0;
                end
                lelc_pkg::ST_DIV_OUT: if (w_rsp.done) r_out <= w_rsp.quo[15:0];
                lelc_pkg::ST_DECIDE: begin
                    r_peakp <= w_peakp;
                    r_tgt   <= w_peakp;
                    r_pos   <= r_lc;
                    r_did_check <= 1'b0;
                    r_zero_lc <= w_quiet_zero;
                    r_step <= '0;
                    r_count <= (r_lc < w_peakp) ? {1'b0, w_peakp - r_lc}
                             : (PW+1)'(lelc_pkg::Depth) - {1'b0, r_lc} + {1'b0, w_peakp};
                    if (w_found) begin
                        r_level <= (r_mode && w_peak < 17'(lelc_pkg::TargetLevel))
                                   ? 17'(lelc_pkg::TargetLevel) : w_peak;
                        if (r_mode) r_quiet <= '0;
                        r_lc <= w_peakp;
                    end else if (w_quiet_hit) begin
                        if (r_quiet <= QW'(lelc_pkg::QuietLimit)) r_quiet <= r_quiet + QW'(1);
                        if (w_quiet_ramp) begin
                            r_level <= '0;
                            r_lc <= w_peakp;
                        end else if (w_quiet_zero) begin
                            r_evalid[w_peakp] <= 1'b1;
                            r_lc <= w_peakp;
                        end
                    end
                end
                lelc_pkg::ST_R_START: ;
                lelc_pkg::ST_R_RD: if (r_step == '0) begin
                    r_start <= (r_erd == 16'd0) ? 17'(lelc_pkg::RampFull) : {1'b0, r_erd};
                end
                lelc_pkg::ST_R_WR: begin
                    r_pos  <= r_pos + PW'(1);
                    r_step <= r_step + (PW+1)'(1);
                end
                lelc_pkg::ST_CHECK: begin
                    r_zero_lc <= 1'b0;
                    r_did_check <= 1'b1;
                    // no corner in the window: ramp down to zero
                    if (w_wrap_ramp) begin
                        r_level <= '0;
                        r_pos <= r_lc;
                        r_tgt <= r_peakp;
                        r_lc <= r_peakp;
                        r_step <= '0;
                        r_count <= (r_lc < r_peakp) ? {1'b0, r_peakp - r_lc}
                                 : (PW+1)'(lelc_pkg::Depth) - {1'b0, r_lc} + {1'b0, r_peakp};
                    end
                end
                lelc_pkg::ST_FINISH: begin
                    r_prev <= r_in;
                    if (w_slope != lelc_pkg::SLOPE_FLAT) r_pslope <= w_slope;
                    r_wp <= w_next;
                end
                lelc_pkg::ST_SEND: if (!r_ovalid) r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // handshake outputs
    assign o_ready      = (r_state == lelc_pkg::ST_IDLE) && !r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;

    `LELC_ASSERT_NXT(a_div_start_idle, i_clk, i_rst_n, w_req.start, w_rsp.busy,
        "divider did not start")
    `LELC_ASSERT_IMP(a_no_ready_busy, i_clk, i_rst_n, w_rsp.busy, !o_ready,
        "ready while divider busy")
    `LELC_ASSERT_IMP(a_ready_no_out, i_clk, i_rst_n, o_ready, !o_valid,
        "ready with result pending")
endmodule

// ----- src/lelc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lelc_div
// shared restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module lelc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lelc_pkg::t_div_req i_req,
    output lelc_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_num, n_num;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [16:0] w_trial;
    logic [16:0] w_sub;

    // one shift-subtract step
    always_comb begin
        w_trial = {r_rem[15:0], r_num[31]};
        w_sub   = w_trial - {1'b0, r_den};
        n_num   = {r_num[30:0], 1'b0};
        n_rem   = w_trial;
        if (!w_sub[16]) begin
            n_rem    = w_sub;
            n_num[0] = 1'b1;
        end
        n_cnt = r_cnt - 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (n_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (32'd0 - r_num) : r_num;
endmodule
